FILE: rtl/wpf_pkg.sv
`timescale 1ns / 1ps

package wpf_pkg;

    // Longest waveform before the block forces an end of waveform
    localparam int WAVEFORM_LENGTH = 1024;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int DEAD_W   = 10;

    // Sample index counter and sum widths follow from the waveform length
    localparam int CNT_W = $clog2(WAVEFORM_LENGTH);
    localparam int SUM_W = CNT_W + SAMPLE_W + 1;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME           = 1'd1;

    // Result kinds
    localparam logic KIND_PEAK     = 1'b0;
    localparam logic KIND_INTEGRAL = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
        logic [POS_W-1:0]           interval;
        logic                       interval_valid;
    } result_t;

endpackage

FILE: rtl/waveform_peak_finder.sv
`timescale 1ns / 1ps

// Gradient-sign peak finder with dead time.
// Input channel: one baseline-corrected sample per beat (sample, last), taken at
// a rising edge with item_valid high and item_stall low. last closes a waveform.
// Result channel: kind/value/position/interval/interval_valid, taken at an edge
// with result_valid high and result_stall low. A peak beat gives the top value,
// its index and the distance from the previous accepted peak; an integral beat
// gives the valley-to-valley sum and the closing valley index.
// A sample's role is known only when the next one arrives, so a result belongs
// to the sample before the one that caused it. The result is registered when
// the next sample is accepted; one sample is taken every cycle while not stalled.
// The work per sample is a subtract, the compares and one accumulate, done
// between the state registers and the result register.
// When the receiver stalls, the result register holds and a skid register takes
// one more result; item_stall rises only while the skid register is occupied.
// Reset (rst_n, asynchronous, active low) clears the waveform state, empties
// both result registers and loads threshold 80 and dead time 10. Configuration
// writes (cfg_valid/cfg_ready, always ready) go to index 0 threshold, 1 dead time.
module waveform_peak_finder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic signed [wpf_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                kind,
    output logic signed [wpf_pkg::VALUE_W-1:0]  value,
    output logic [wpf_pkg::POS_W-1:0]           position,
    output logic [wpf_pkg::POS_W-1:0]           interval,
    output logic                                interval_valid,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wpf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wpf_pkg::SAMPLE_W-1:0]        cfg_data
);
    import wpf_pkg::*;

    // Configuration
    logic signed [SAMPLE_W-1:0] threshold_reg;
    logic [DEAD_W-1:0]          dead_time_reg;

    // Waveform state
    logic signed [SAMPLE_W-1:0] prev_sample_reg, prev_sample_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       rising_reg, rising_next;
    logic                       peak_since_valley_reg, peak_since_valley_next;
    logic [CNT_W-1:0]           last_peak_reg, last_peak_next;
    logic                       have_peak_reg, have_peak_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;

    // Result registers
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic                       accept;
    logic                       out_free;
    logic                       is_end;
    logic                       judge;
    logic [CNT_W-1:0]           p;
    logic signed [SAMPLE_W:0]   grad;
    logic signed [SUM_W-1:0]    acc;
    logic signed [63:0]         acc_wide;
    logic [CNT_W-1:0]           gap;
    logic                       res_fire;
    result_t                    res;

    assign cfg_ready  = 1'b1;
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !skid_valid_reg;
    assign out_free   = !out_valid_reg || !result_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= SAMPLE_W'(80);
            dead_time_reg <= DEAD_W'(10);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_AMPLITUDE_THRESHOLD: threshold_reg <= cfg_data;
                REG_DEAD_TIME:           dead_time_reg <= cfg_data[DEAD_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Judge the previous sample against the incoming one
    assign is_end   = last || (count_reg >= CNT_W'(WAVEFORM_LENGTH - 1));
    assign judge    = count_reg >= CNT_W'(2);
    assign p        = count_reg - CNT_W'(1);
    assign grad     = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(prev_sample_reg);
    assign acc      = sum_reg + SUM_W'(prev_sample_reg);
    assign acc_wide = 64'(acc);
    assign gap      = p - last_peak_reg;

    always_comb
    begin
        prev_sample_next       = prev_sample_reg;
        count_next             = count_reg;
        rising_next            = rising_reg;
        peak_since_valley_next = peak_since_valley_reg;
        last_peak_next         = last_peak_reg;
        have_peak_next         = have_peak_reg;
        sum_next               = sum_reg;
        res_fire               = 1'b0;
        res.kind               = KIND_PEAK;
        res.value              = VALUE_W'(prev_sample_reg);
        res.position           = POS_W'(p);
        res.interval           = '0;
        res.interval_valid     = 1'b0;

        if (judge)
        begin
            if (grad > 0 && !rising_reg)
            begin
                // Valley: close the integral of the last accepted peak
                if (peak_since_valley_reg)
                begin
                    res_fire  = 1'b1;
                    res.kind  = KIND_INTEGRAL;
                    if (acc_wide > 64'sd2147483647)
                        res.value = 32'sh7FFFFFFF;
                    else if (acc_wide < -64'sd2147483648)
                        res.value = 32'sh80000000;
                    else
                        res.value = acc_wide[VALUE_W-1:0];
                    peak_since_valley_next = 1'b0;
                end
                rising_next = 1'b1;
                sum_next    = SUM_W'(prev_sample_reg);
            end
            else
            begin
                sum_next = acc;
                if (grad < 0 && rising_reg)
                begin
                    // Top: accept above threshold and past the dead time
                    if (prev_sample_reg > threshold_reg &&
                        32'(gap) > 32'(dead_time_reg))
                    begin
                        res_fire = 1'b1;
                        if (have_peak_reg)
                        begin
                            res.interval_valid = 1'b1;
                            res.interval = (32'(gap) > 32'(POS_MAX)) ? POS_MAX
                                                                     : POS_W'(gap);
                        end
                        last_peak_next         = p;
                        have_peak_next         = 1'b1;
                        peak_since_valley_next = 1'b1;
                    end
                    rising_next = 1'b0;
                end
            end
        end

        if (is_end)
        begin
            prev_sample_next       = '0;
            count_next             = '0;
            rising_next            = 1'b0;
            peak_since_valley_next = 1'b0;
            last_peak_next         = '0;
            have_peak_next         = 1'b0;
            sum_next               = '0;
        end
        else
        begin
            prev_sample_next = sample;
            count_next       = count_reg + CNT_W'(1);
        end
    end

    // Advance waveform state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg       <= '0;
            count_reg             <= '0;
            rising_reg            <= 1'b0;
            peak_since_valley_reg <= 1'b0;
            last_peak_reg         <= '0;
            have_peak_reg         <= 1'b0;
            sum_reg               <= '0;
        end
        else if (accept)
        begin
            prev_sample_reg       <= prev_sample_next;
            count_reg             <= count_next;
            rising_reg            <= rising_next;
            peak_since_valley_reg <= peak_since_valley_next;
            last_peak_reg         <= last_peak_next;
            have_peak_reg         <= have_peak_next;
            sum_reg               <= sum_next;
        end
    end

    // Output register and skid register control. Input is stalled while the
    // skid register is full, so a new result never meets a full skid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res_fire)
        begin
            if (out_free)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
                out_reg <= skid_reg;
        end
        else if (accept && res_fire)
        begin
            if (out_free)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign result_valid   = out_valid_reg;
    assign kind           = out_reg.kind;
    assign value          = out_reg.value;
    assign position       = out_reg.position;
    assign interval       = out_reg.interval;
    assign interval_valid = out_reg.interval_valid;

    // Skid register is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while output register is empty");

    // Integral results carry no interval
    a_integral_no_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_INTEGRAL) |->
        (!out_reg.interval_valid && out_reg.interval == '0))
        else $error("integral result carries an interval");

    // A pending integral needs an accepted peak
    a_psv_needs_peak: assert property (@(posedge clk) disable iff (!rst_n)
        peak_since_valley_reg |-> have_peak_reg)
        else $error("peak since valley without an accepted peak");

    // Peaks are never recorded at index zero, so the position tracks the flag
    a_peak_pos_flag: assert property (@(posedge clk) disable iff (!rst_n)
        have_peak_reg == (last_peak_reg != '0))
        else $error("last peak position disagrees with have_peak");

    // The final sample of a waveform clears the index counter
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (count_reg == '0 && !rising_reg))
        else $error("waveform state not cleared after final sample");

endmodule
